// ===== src/bmsf_pkg.sv =====
// Package for the bit map set/find engine: opcodes, field widths, the command
// token that walks the cell chain, and the bit-search helper functions.
// No dependencies.
package bmsf_pkg;

	// Fixed widths of the item fields.
	localparam int IdxW    = 10;
	localparam int BitW    = 6;
	localparam int WordIdW = IdxW - BitW;
	localparam int PosW    = 8;
	localparam int WordW   = 64;

	// Command codes.
	typedef enum logic [3:0] {
		OP_TEST       = 4'd0,
		OP_SET        = 4'd1,
		OP_CLEAR      = 4'd2,
		OP_FLIP       = 4'd3,
		OP_TEST_SET   = 4'd4,
		OP_TEST_CLEAR = 4'd5,
		OP_NEXT_SET   = 4'd6,
		OP_NEXT_CLEAR = 4'd7,
		OP_HIGHEST    = 4'd8,
		OP_EMPTY      = 4'd9,
		OP_CLEAR_ALL  = 4'd10
	} opcode_t;

	// Command token handed from cell to cell, with the result built so far.
	typedef struct packed {
		logic                 valid;
		opcode_t              op;
		logic [IdxW-1:0]      idx;
		logic                 flag;
		logic                 found;
		logic [PosW-1:0]      pos;
		logic                 status;
	} token_t;

	// Position of the lowest set bit of a word; zero when the word is zero.
	function automatic logic [BitW-1:0] lowest_one(input logic [WordW-1:0] w);
		logic [BitW-1:0] r;
		r = '0;
		for (int b = WordW - 1; b >= 0; b--) begin
			if (w[b]) r = BitW'(b);
		end
		return r;
	endfunction

	// Position of the highest set bit of a word; zero when the word is zero.
	function automatic logic [BitW-1:0] highest_one(input logic [WordW-1:0] w);
		logic [BitW-1:0] r;
		r = '0;
		for (int b = 0; b < WordW; b++) begin
			if (w[b]) r = BitW'(b);
		end
		return r;
	endfunction

endpackage

// ===== src/bmsf_cell.sv =====
// One cell of the bit map chain: holds one 64-bit word of the map, applies the
// passing command token to it and hands the token on to the next cell.
// Depends on bmsf_pkg.
module bmsf_cell #(
	parameter int CELL_ID = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  bmsf_pkg::token_t tok_in,
	output bmsf_pkg::token_t tok_q
);

	localparam logic [bmsf_pkg::WordIdW-1:0] MyId = bmsf_pkg::WordIdW'(CELL_ID);
	localparam logic [bmsf_pkg::PosW-bmsf_pkg::BitW-1:0] PosHi =
		(bmsf_pkg::PosW - bmsf_pkg::BitW)'(CELL_ID);

	logic [bmsf_pkg::WordW-1:0]   word_q;
	logic [bmsf_pkg::WordW-1:0]   word_d;
	bmsf_pkg::token_t             tok_d;
	logic [bmsf_pkg::WordIdW-1:0] tok_word;
	logic [bmsf_pkg::BitW-1:0]    tok_bit;
	logic                         mine;
	logic                         in_scan;
	logic [bmsf_pkg::WordW-1:0]   scan_v;

	assign tok_word = tok_in.idx[bmsf_pkg::IdxW-1:bmsf_pkg::BitW];
	assign tok_bit  = tok_in.idx[bmsf_pkg::BitW-1:0];
	assign mine     = (tok_word == MyId);
	assign in_scan  = (tok_word <= MyId);

	// Scan word for the find commands, masked below the start bit in the start word.
	always_comb begin
		scan_v = (tok_in.op == bmsf_pkg::OP_NEXT_SET) ? word_q : ~word_q;
		if (mine) scan_v = scan_v & ({bmsf_pkg::WordW{1'b1}} << tok_bit);
	end

	// Apply the command to this word and update the partial result.
	always_comb begin
		word_d = word_q;
		tok_d  = tok_in;
		if (tok_in.valid && !tok_in.status) begin
			unique case (tok_in.op)
				bmsf_pkg::OP_TEST: begin
					if (mine) tok_d.flag = word_q[tok_bit];
				end
				bmsf_pkg::OP_SET: begin
					if (mine) word_d[tok_bit] = 1'b1;
				end
				bmsf_pkg::OP_CLEAR: begin
					if (mine) word_d[tok_bit] = 1'b0;
				end
				bmsf_pkg::OP_FLIP: begin
					if (mine) word_d[tok_bit] = ~word_q[tok_bit];
				end
				bmsf_pkg::OP_TEST_SET: begin
					if (mine) begin
						tok_d.flag      = word_q[tok_bit];
						word_d[tok_bit] = 1'b1;
					end
				end
				bmsf_pkg::OP_TEST_CLEAR: begin
					if (mine) begin
						tok_d.flag      = word_q[tok_bit];
						word_d[tok_bit] = 1'b0;
					end
				end
				bmsf_pkg::OP_NEXT_SET, bmsf_pkg::OP_NEXT_CLEAR: begin
					if (!tok_in.found && in_scan && (scan_v != '0)) begin
						tok_d.found = 1'b1;
						tok_d.pos   = {PosHi, bmsf_pkg::lowest_one(scan_v)};
					end
				end
				bmsf_pkg::OP_HIGHEST: begin
					// Later cells hold higher bits, so the last nonzero word wins.
					if (word_q != '0) begin
						tok_d.found = 1'b1;
						tok_d.pos   = {PosHi, bmsf_pkg::highest_one(word_q)};
					end
				end
				bmsf_pkg::OP_EMPTY: begin
					if (word_q != '0) tok_d.flag = 1'b0;
				end
				bmsf_pkg::OP_CLEAR_ALL: begin
					word_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Word and token registers advance together, so a held token is applied once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			tok_q  <= '0;
		end else if (adv) begin
			if (tok_in.valid) word_q <= word_d;
			tok_q <= tok_d;
		end
	end

endmodule

// ===== src/bitmap_set_find_engine_top.sv =====
// Top level of the bit map set/find engine: a chain of bmsf_cell instances,
// one per 64-bit word, plus the input admission and the output register.
// Depends on bmsf_pkg and bmsf_cell.
//
// Usage: commands enter on the s_axis channel, one item per handshake, and
// each command gives exactly one result item on the m_axis channel.
// A command token walks the cell chain, one cell (one 64-bit word) per
// cycle, so every command, find or not, passes all NUM_WORDS cells.
// m_axis_tvalid rises when the token moves from the last cell register into
// the output register. One command is in flight at a time: s_axis_tready
// rises again together with m_axis_tvalid, so the engine takes no new
// command before the last one has passed the whole cell chain.
// The next command is accepted while a finished result still waits in the
// output register. If the receiver stalls, the token holds at the end of
// the chain and the map is not touched until the result can move on.
// Out-of-range indexes (word >= NUM_WORDS) are flagged in status and leave
// the map unchanged. Reset clears the whole map and drops any item in flight.
module bitmap_set_find_engine_top #(
	parameter int NUM_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // opcode[3:0], bit_index[13:4], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // flag[0], found[1], position[9:2], status[10]
);

	localparam logic [bmsf_pkg::WordIdW:0] NumWordsW = (bmsf_pkg::WordIdW + 1)'(NUM_WORDS);

	bmsf_pkg::token_t             tok [NUM_WORDS+1];
	bmsf_pkg::token_t             last_tok;
	logic                         busy_q;
	logic                         out_valid_q;
	logic [10:0]                  out_data_q;
	logic                         out_adv;
	logic                         adv;
	logic                         accept;
	bmsf_pkg::opcode_t            in_op;
	logic [bmsf_pkg::IdxW-1:0]    in_idx;
	logic                         in_range_err;

	assign in_op  = bmsf_pkg::opcode_t'(s_axis_tdata[3:0]);
	assign in_idx = s_axis_tdata[13:4];

	// The output register loads when it is empty or being read; the chain only
	// stops when a finished token has nowhere to go.
	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_adv       = !out_valid_q || m_axis_tready;
	assign adv           = out_adv || !last_tok.valid;

	// Indexed commands past the map capacity are rejected at entry.
	assign in_range_err = (s_axis_tdata[3:0] <= 4'(bmsf_pkg::OP_NEXT_CLEAR)) &&
		({1'b0, in_idx[bmsf_pkg::IdxW-1:bmsf_pkg::BitW]} >= NumWordsW);

	// Build the entering token with its initial result fields.
	always_comb begin
		tok[0].valid  = accept;
		tok[0].op     = in_op;
		tok[0].idx    = in_idx;
		tok[0].flag   = (in_op == bmsf_pkg::OP_EMPTY);
		tok[0].found  = 1'b0;
		tok[0].pos    = '0;
		tok[0].status = in_range_err;
	end

	// Chain of word cells.
	for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
		bmsf_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.tok_in(tok[i]),
			.tok_q (tok[i+1])
		);
	end

	assign last_tok = tok[NUM_WORDS];

	// Admission control and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last_tok.valid && out_adv) begin
				busy_q <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= last_tok.valid;
				if (last_tok.valid) begin
					out_data_q <= {last_tok.status, last_tok.pos, last_tok.found,
						last_tok.flag};
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_data_q};

endmodule
